### src/binary_min_heap_queue_assert.svh
// Assertion macros used by the heap queue checker.
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define BMHQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked through reset as well.
`define BMHQ_ASSERT_NXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bmhq_pkg.sv
// Shared widths, codes and defaults of the binary min-heap queue.
package bmhq_pkg;

  localparam int KEY_W        = 64;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 11;
  localparam int DEF_CAPACITY = 1024;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_PAD_W  = OUT_DATA_W - KEY_W - COUNT_W;

  // Operation codes; the unused code behaves as a read.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

### src/bmhq_ram.sv
// Heap key store: one write port, two read ports with registered data.
module bmhq_ram #(
  parameter int DEPTH = bmhq_pkg::DEF_CAPACITY,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic signed [bmhq_pkg::KEY_W-1:0] wr_data,
  input  logic [AW-1:0]                     rd_addr_a,
  input  logic [AW-1:0]                     rd_addr_b,
  output logic signed [bmhq_pkg::KEY_W-1:0] rd_data_a,
  output logic signed [bmhq_pkg::KEY_W-1:0] rd_data_b
);

  logic signed [bmhq_pkg::KEY_W-1:0] mem [DEPTH];

  // Write one key
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read two keys, data in the next cycle
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

### src/bmhq_cmp.sv
// Shared signed key comparator used by the sift-up and sift-down compare steps.
module bmhq_cmp (
  input  logic signed [bmhq_pkg::KEY_W-1:0] a,
  input  logic signed [bmhq_pkg::KEY_W-1:0] b,
  output logic                              less
);

  // Flag a strictly below b
  assign less = (a < b);

endmodule

### src/binary_min_heap_queue.sv
// A read, a refused op, a first insert or a delete of the last key go straight to the
// result; an insert sifts up a level per step; a delete leaving one key moves the last key
// to the root, else it sifts down with a select and a swap step per level; a place step
// ends a sift that runs to the top or bottom. The sift sequencer, with one comparator and
// one store write port, takes one item at a time; the next is taken while a result waits.
// Reset clears the fill count, sequencer and output valid; the key store is not cleared.
module binary_min_heap_queue #(
  parameter int CAPACITY = bmhq_pkg::DEF_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [63:0] key_value
  input  logic [bmhq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [1:0] opcode
  input  logic [bmhq_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [63:0] min_value, [74:64] entry_count, [79:75] zero
  output logic [bmhq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [1:0] status
  output logic [bmhq_pkg::STATUS_W-1:0]       m_axis_tuser
);

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int KW = bmhq_pkg::KEY_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP      = 3'd1;
  localparam logic [2:0] S_DN_LAST = 3'd2;
  localparam logic [2:0] S_DN_SEL  = 3'd3;
  localparam logic [2:0] S_DN_SWP  = 3'd4;
  localparam logic [2:0] S_PLACE   = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]               state;
  logic [PW-1:0]            count;
  logic [PW-1:0]            pos;
  logic [PW-1:0]            kid;
  logic signed [KW-1:0]     key;
  logic signed [KW-1:0]     child_key;
  logic signed [KW-1:0]     root;
  logic signed [KW-1:0]     res_min;
  logic [bmhq_pkg::STATUS_W-1:0] res_status;
  logic                     res_from_root;

  logic signed [KW-1:0]     out_min;
  logic [bmhq_pkg::COUNT_W-1:0] out_count;

  logic                     in_fire;
  logic [bmhq_pkg::OP_W-1:0] in_op;
  logic signed [KW-1:0]     in_key;

  logic                     wr_en;
  logic [PW-1:0]            wr_pos;
  logic signed [KW-1:0]     wr_data;
  logic [PW:0]              rd_pos_a;
  logic [PW:0]              rd_pos_b;
  logic signed [KW-1:0]     rd_data_a;
  logic signed [KW-1:0]     rd_data_b;
  logic signed [KW-1:0]     cmp_a;
  logic signed [KW-1:0]     cmp_b;
  logic                     cmp_less;

  logic [PW-1:0]            count_inc;
  logic [PW-1:0]            pos_half;
  logic [PW:0]              child_l;
  logic [PW:0]              child_r;
  logic [PW:0]              kid_l;
  logic [PW:0]              kid_r;
  logic                     has_right;
  logic                     is_full;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign in_op     = s_axis_tuser;
  assign in_key    = s_axis_tdata[KW-1:0];
  assign s_axis_tready = (state == S_IDLE);

  assign count_inc = PW'(count + 1'b1);
  assign pos_half  = pos >> 1;
  assign child_l   = {pos, 1'b0};
  assign child_r   = {pos, 1'b1};
  assign kid_l     = {kid, 1'b0};
  assign kid_r     = {kid, 1'b1};
  assign has_right = (child_r <= {1'b0, count});
  assign is_full   = (count == PW'(CAPACITY));

  bmhq_ram #(
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (AW'(wr_pos - 1'b1)),
    .wr_data   (wr_data),
    .rd_addr_a (AW'(rd_pos_a - 1'b1)),
    .rd_addr_b (AW'(rd_pos_b - 1'b1)),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  bmhq_cmp u_cmp (
    .a    (cmp_a),
    .b    (cmp_b),
    .less (cmp_less)
  );

  // Steer the store ports and the comparator for the current step
  always_comb begin
    wr_en    = 1'b0;
    wr_pos   = pos;
    wr_data  = key;
    rd_pos_a = '0;
    rd_pos_b = '0;
    cmp_a    = key;
    cmp_b    = rd_data_a;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_op)
            bmhq_pkg::OP_INSERT: begin
              if (!is_full && count == '0) begin
                wr_en   = 1'b1;
                wr_pos  = PW'(1);
                wr_data = in_key;
              end
              rd_pos_a = {1'b0, count_inc >> 1};
            end
            bmhq_pkg::OP_DELETE: begin
              rd_pos_a = {1'b0, count};
            end
            default: begin
            end
          endcase
        end
      end
      S_UP: begin
        wr_en = 1'b1;
        if (cmp_less) begin
          wr_data  = rd_data_a;
          rd_pos_a = {1'b0, pos_half >> 1};
        end
      end
      S_DN_LAST: begin
        if (count == PW'(1)) begin
          wr_en   = 1'b1;
          wr_pos  = PW'(1);
          wr_data = rd_data_a;
        end
        rd_pos_a = (PW+1)'(2);
        rd_pos_b = (PW+1)'(3);
      end
      S_DN_SEL: begin
        cmp_a = rd_data_b;
        cmp_b = rd_data_a;
      end
      S_DN_SWP: begin
        cmp_a = child_key;
        cmp_b = key;
        wr_en = 1'b1;
        if (cmp_less) begin
          wr_data  = child_key;
          rd_pos_a = kid_l;
          rd_pos_b = kid_r;
        end
      end
      S_PLACE: begin
        wr_en = 1'b1;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Sequence one operation through the sift steps
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            res_status    <= bmhq_pkg::ST_OK;
            res_min       <= root;
            res_from_root <= 1'b0;
            key           <= in_key;
            state         <= S_DONE;
            unique case (in_op)
              bmhq_pkg::OP_INSERT: begin
                res_from_root <= 1'b1;
                if (is_full) begin
                  res_status <= bmhq_pkg::ST_FULL;
                end else begin
                  count <= count_inc;
                  pos   <= count_inc;
                  if (count != '0) begin
                    state <= S_UP;
                  end
                end
              end
              bmhq_pkg::OP_DELETE: begin
                if (count == '0) begin
                  res_status <= bmhq_pkg::ST_EMPTY;
                  res_min    <= '0;
                end else begin
                  count <= PW'(count - 1'b1);
                  if (count != PW'(1)) begin
                    state <= S_DN_LAST;
                  end
                end
              end
              default: begin
                if (count == '0) begin
                  res_status <= bmhq_pkg::ST_EMPTY;
                  res_min    <= '0;
                end
              end
            endcase
          end
        end
        S_UP: begin
          if (cmp_less) begin
            pos   <= pos_half;
            state <= (pos_half == PW'(1)) ? S_PLACE : S_UP;
          end else begin
            state <= S_DONE;
          end
        end
        S_DN_LAST: begin
          key   <= rd_data_a;
          pos   <= PW'(1);
          state <= (count == PW'(1)) ? S_DONE : S_DN_SEL;
        end
        S_DN_SEL: begin
          if (has_right && cmp_less) begin
            child_key <= rd_data_b;
            kid       <= PW'(child_r);
          end else begin
            child_key <= rd_data_a;
            kid       <= PW'(child_l);
          end
          state <= S_DN_SWP;
        end
        S_DN_SWP: begin
          if (cmp_less) begin
            pos   <= kid;
            state <= (kid_l <= {1'b0, count}) ? S_DN_SEL : S_PLACE;
          end else begin
            state <= S_DONE;
          end
        end
        S_PLACE: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Mirror the root slot for fast minimum reads
  always_ff @(posedge clk) begin
    if (wr_en && wr_pos == PW'(1)) begin
      root <= wr_data;
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      out_min      <= res_from_root ? root : res_min;
      out_count    <= bmhq_pkg::COUNT_W'(count);
      m_axis_tuser <= res_status;
    end
  end

  assign m_axis_tdata = {{bmhq_pkg::OUT_PAD_W{1'b0}}, out_count, out_min};

endmodule

### src/bmhq_checker.sv
// Port-level checks of the heap queue, bound to the top level.
`include "binary_min_heap_queue_assert.svh"

module bmhq_checker #(
  parameter int CAPACITY = bmhq_pkg::DEF_CAPACITY
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [bmhq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input logic [bmhq_pkg::STATUS_W-1:0]       m_axis_tuser
);

  localparam int KW = bmhq_pkg::KEY_W;
  localparam int CW = bmhq_pkg::COUNT_W;

  logic [CW-1:0] obs_count;
  logic [KW-1:0] obs_min;

  assign obs_count = m_axis_tdata[KW+CW-1:KW];
  assign obs_min   = m_axis_tdata[KW-1:0];

  // A refused insert reports a full store
  `BMHQ_ASSERT_IMP(a_full_count, clk, rst, m_axis_tvalid && m_axis_tuser == bmhq_pkg::ST_FULL, obs_count == CW'(CAPACITY), "full status with count below capacity")

  // An empty answer carries a zero key and zero count
  `BMHQ_ASSERT_IMP(a_empty_zero, clk, rst, m_axis_tvalid && m_axis_tuser == bmhq_pkg::ST_EMPTY, obs_min == '0 && obs_count == '0, "empty status with nonzero payload")

  // Reset leaves no result pending
  `BMHQ_ASSERT_NXT(a_reset_idle, clk, rst, !m_axis_tvalid, "result valid right after reset")

  // A stalled result holds its payload
  `BMHQ_ASSERT_IMP(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready, ##1 (rst || (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))), "stalled result changed")

  // A taken item keeps the input closed for the next cycle
  `BMHQ_ASSERT_IMP(a_take_busy, clk, rst, s_axis_tvalid && s_axis_tready, ##1 !s_axis_tready, "input ready right after an item was taken")

endmodule

bind binary_min_heap_queue bmhq_checker #(.CAPACITY(CAPACITY)) u_bmhq_checker (.*);
